// File: design/vnc_pkg.sv
package vnc_pkg;

  // Fixed-point constants
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam int unsigned SQRT_STAGES = 32;  // one root bit per stage
  localparam int unsigned DIV_STAGES = 31;   // one quotient bit per stage
  localparam int unsigned FRONT_STAGES = 7;
  localparam int unsigned BACK_STAGES = 5;   // includes output register
  // Accept edge to result-accept edge
  localparam int unsigned PIPE_LAT = FRONT_STAGES + SQRT_STAGES + 1 + DIV_STAGES
                                     + BACK_STAGES;

  localparam logic [24:0] TOL_RESET = 25'd17;

  typedef enum logic [1:0] {
    REG_ORIENT_X = 2'd0,
    REG_ORIENT_Y = 2'd1,
    REG_ORIENT_VALID = 2'd2,
    REG_EQUAL_TOL = 2'd3
  } vnc_reg_t;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic valid;
    logic [24:0] tol;
  } vnc_cfg_t;

  // Per-point data that rides along the sqrt and divide pipes
  typedef struct packed {
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic signed [31:0] ox;   // clamped orientation
    logic signed [31:0] oy;
    logic miss;
    logic conf;               // scales equal within tolerance
    logic a_neg;
    logic b_neg;
    logic [30:0] ma;          // normalized magnitudes
    logic [30:0] mb;
  } vnc_side_t;

  function automatic logic signed [31:0] clamp_q30(input logic signed [31:0] x);
    logic signed [31:0] y;
    y = x;
    if (x > ONE_Q30) y = ONE_Q30;
    if (x < -ONE_Q30) y = -ONE_Q30;
    return y;
  endfunction

endpackage

// File: design/vnc_front.sv
module vnc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic signed [31:0]      in_u,
  input  logic signed [31:0]      in_v,
  input  logic                    in_miss,
  input  logic [31:0]             in_sx,
  input  logic [31:0]             in_sy,
  input  vnc_pkg::vnc_cfg_t       cfg,
  output logic                    out_vld,
  output vnc_pkg::vnc_side_t      out_side,
  output logic [62:0]             out_rad
);

  // F1: capture, conformal test, clamp
  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r, vld6_r, vld7_r;
  logic signed [31:0] u1_r, v1_r, ox1_r, oy1_r;
  logic miss1_r, conf1_r;
  logic [31:0] sx1_r, sy1_r;
  logic [31:0] sdiff;

  always_comb begin
    sdiff = (in_sx >= in_sy) ? (in_sx - in_sy) : (in_sy - in_sx);
  end

  always_ff @(posedge clk) begin
    u1_r <= in_u;
    v1_r <= in_v;
    miss1_r <= in_miss;
    sx1_r <= in_sx;
    sy1_r <= in_sy;
    conf1_r <= (sdiff <= {7'd0, cfg.tol});
    ox1_r <= vnc_pkg::clamp_q30(cfg.ox);
    oy1_r <= vnc_pkg::clamp_q30(cfg.oy);
  end

  // F2: scale cross products
  logic signed [64:0] pa, pb;
  logic signed [63:0] a2_r, b2_r;
  logic signed [31:0] u2_r, v2_r, ox2_r, oy2_r;
  logic miss2_r, conf2_r;

  always_comb begin
    pa = ox1_r * $signed({1'b0, sy1_r});
    pb = oy1_r * $signed({1'b0, sx1_r});
  end

  always_ff @(posedge clk) begin
    a2_r <= pa[63:0];
    b2_r <= pb[63:0];
    u2_r <= u1_r;
    v2_r <= v1_r;
    ox2_r <= ox1_r;
    oy2_r <= oy1_r;
    miss2_r <= miss1_r;
    conf2_r <= conf1_r;
  end

  // F3: magnitudes and max
  logic [63:0] ma_w, mb_w;
  logic [62:0] ma3_r, mb3_r, m3_r;
  logic an3_r, bn3_r;
  logic signed [31:0] u3_r, v3_r, ox3_r, oy3_r;
  logic miss3_r, conf3_r;

  always_comb begin
    ma_w = a2_r[63] ? 64'(-a2_r) : 64'(a2_r);
    mb_w = b2_r[63] ? 64'(-b2_r) : 64'(b2_r);
  end

  always_ff @(posedge clk) begin
    ma3_r <= ma_w[62:0];
    mb3_r <= mb_w[62:0];
    m3_r <= (ma_w > mb_w) ? ma_w[62:0] : mb_w[62:0];
    an3_r <= a2_r[63];
    bn3_r <= b2_r[63];
    u3_r <= u2_r;
    v3_r <= v2_r;
    ox3_r <= ox2_r;
    oy3_r <= oy2_r;
    miss3_r <= miss2_r;
    conf3_r <= conf2_r;
  end

  // F4: shift count so that max >> k < 2^31
  logic [5:0] k_w, k4_r;
  logic [62:0] ma4_r, mb4_r;
  logic an4_r, bn4_r;
  logic signed [31:0] u4_r, v4_r, ox4_r, oy4_r;
  logic miss4_r, conf4_r;

  always_comb begin
    k_w = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (m3_r[31 + i]) k_w = 6'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    k4_r <= k_w;
    ma4_r <= ma3_r;
    mb4_r <= mb3_r;
    an4_r <= an3_r;
    bn4_r <= bn3_r;
    u4_r <= u3_r;
    v4_r <= v3_r;
    ox4_r <= ox3_r;
    oy4_r <= oy3_r;
    miss4_r <= miss3_r;
    conf4_r <= conf3_r;
  end

  // F5: normalize
  logic [62:0] sha, shb;
  vnc_pkg::vnc_side_t side5_r, side6_r, side7_r;

  always_comb begin
    sha = ma4_r >> k4_r;
    shb = mb4_r >> k4_r;
  end

  always_ff @(posedge clk) begin
    side5_r.u <= u4_r;
    side5_r.v <= v4_r;
    side5_r.ox <= ox4_r;
    side5_r.oy <= oy4_r;
    side5_r.miss <= miss4_r;
    side5_r.conf <= conf4_r;
    side5_r.a_neg <= an4_r;
    side5_r.b_neg <= bn4_r;
    side5_r.ma <= sha[30:0];
    side5_r.mb <= shb[30:0];
  end

  // F6: squares
  logic [61:0] sqa6_r, sqb6_r;

  always_ff @(posedge clk) begin
    sqa6_r <= side5_r.ma * side5_r.ma;
    sqb6_r <= side5_r.mb * side5_r.mb;
    side6_r <= side5_r;
  end

  // F7: sum of squares
  logic [62:0] rad7_r;

  always_ff @(posedge clk) begin
    rad7_r <= {1'b0, sqa6_r} + {1'b0, sqb6_r};
    side7_r <= side6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
    end
  end

  assign out_vld = vld7_r;
  assign out_side = side7_r;
  assign out_rad = rad7_r;

endmodule

// File: design/vnc_sqrt.sv
module vnc_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  vnc_pkg::vnc_side_t in_side,
  input  logic [62:0]        in_rad,
  output logic               out_vld,
  output vnc_pkg::vnc_side_t out_side,
  output logic [31:0]        out_root
);

  localparam int unsigned N = vnc_pkg::SQRT_STAGES;

  logic vld_r [N];
  vnc_pkg::vnc_side_t side_r [N];
  logic [33:0] rem_r [N];
  logic [31:0] root_r [N];
  logic [63:0] rad_r [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic p_vld;
    vnc_pkg::vnc_side_t p_side;
    logic [33:0] p_rem;
    logic [31:0] p_root;
    logic [63:0] p_rad;
    logic [35:0] cur, trial;

    if (g == 0) begin : g_first
      assign p_vld = in_vld;
      assign p_side = in_side;
      assign p_rem = 34'd0;
      assign p_root = 32'd0;
      assign p_rad = {1'b0, in_rad};
    end else begin : g_next
      assign p_vld = vld_r[g-1];
      assign p_side = side_r[g-1];
      assign p_rem = rem_r[g-1];
      assign p_root = root_r[g-1];
      assign p_rad = rad_r[g-1];
    end

    always_comb begin
      cur = {p_rem, p_rad[63:62]};
      trial = {2'b00, p_root, 2'b01};
    end

    always_ff @(posedge clk) begin
      side_r[g] <= p_side;
      rad_r[g] <= {p_rad[61:0], 2'b00};
      if (cur >= trial) begin
        rem_r[g] <= 34'(cur - trial);
        root_r[g] <= {p_root[30:0], 1'b1};
      end else begin
        rem_r[g] <= cur[33:0];
        root_r[g] <= {p_root[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= p_vld;
      end
    end
  end

  assign out_vld = vld_r[N-1];
  assign out_side = side_r[N-1];
  assign out_root = root_r[N-1];

endmodule

// File: design/vnc_div.sv
module vnc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  vnc_pkg::vnc_side_t in_side,
  input  logic [31:0]        in_root,
  output logic               out_vld,
  output vnc_pkg::vnc_side_t out_side,
  output logic [30:0]        out_qa,
  output logic [30:0]        out_qb,
  output logic               out_rzero
);

  localparam int unsigned N = vnc_pkg::DIV_STAGES;

  // Prep: dividend = mag * 2^30 + root/2; quotient fits 31 bits
  logic [61:0] da, db;
  logic p_vld_r;
  vnc_pkg::vnc_side_t p_side_r;
  logic [31:0] p_r_r, p_rema_r, p_remb_r;
  logic [30:0] p_lowa_r, p_lowb_r;

  always_comb begin
    da = {1'b0, in_side.ma, 30'd0} + {31'd0, in_root[31:1]};
    db = {1'b0, in_side.mb, 30'd0} + {31'd0, in_root[31:1]};
  end

  always_ff @(posedge clk) begin
    p_side_r <= in_side;
    p_r_r <= in_root;
    p_rema_r <= {1'b0, da[61:31]};
    p_remb_r <= {1'b0, db[61:31]};
    p_lowa_r <= da[30:0];
    p_lowb_r <= db[30:0];
  end

  logic vld_r [N];
  vnc_pkg::vnc_side_t side_r [N];
  logic [31:0] r_r [N];
  logic [31:0] rema_r [N], remb_r [N];
  logic [30:0] lowa_r [N], lowb_r [N];
  logic [30:0] qa_r [N], qb_r [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic pv;
    vnc_pkg::vnc_side_t ps;
    logic [31:0] pr, pra, prb;
    logic [30:0] pla, plb, pqa, pqb;
    logic [32:0] ca, cb;

    if (g == 0) begin : g_first
      assign pv = p_vld_r;
      assign ps = p_side_r;
      assign pr = p_r_r;
      assign pra = p_rema_r;
      assign prb = p_remb_r;
      assign pla = p_lowa_r;
      assign plb = p_lowb_r;
      assign pqa = 31'd0;
      assign pqb = 31'd0;
    end else begin : g_next
      assign pv = vld_r[g-1];
      assign ps = side_r[g-1];
      assign pr = r_r[g-1];
      assign pra = rema_r[g-1];
      assign prb = remb_r[g-1];
      assign pla = lowa_r[g-1];
      assign plb = lowb_r[g-1];
      assign pqa = qa_r[g-1];
      assign pqb = qb_r[g-1];
    end

    always_comb begin
      ca = {pra, pla[30]};
      cb = {prb, plb[30]};
    end

    always_ff @(posedge clk) begin
      side_r[g] <= ps;
      r_r[g] <= pr;
      lowa_r[g] <= {pla[29:0], 1'b0};
      lowb_r[g] <= {plb[29:0], 1'b0};
      if (ca >= {1'b0, pr}) begin
        rema_r[g] <= 32'(ca - {1'b0, pr});
        qa_r[g] <= {pqa[29:0], 1'b1};
      end else begin
        rema_r[g] <= ca[31:0];
        qa_r[g] <= {pqa[29:0], 1'b0};
      end
      if (cb >= {1'b0, pr}) begin
        remb_r[g] <= 32'(cb - {1'b0, pr});
        qb_r[g] <= {pqb[29:0], 1'b1};
      end else begin
        remb_r[g] <= cb[31:0];
        qb_r[g] <= {pqb[29:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= pv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= in_vld;
    end
  end

  assign out_vld = vld_r[N-1];
  assign out_side = side_r[N-1];
  assign out_qa = qa_r[N-1];
  assign out_qb = qb_r[N-1];
  assign out_rzero = (r_r[N-1] == 32'd0);

endmodule

// File: design/vnc_back.sv
module vnc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  vnc_pkg::vnc_side_t in_side,
  input  logic [30:0]        in_qa,
  input  logic [30:0]        in_qb,
  input  logic               in_rzero,
  input  logic               orient_valid,
  output logic               out_strobe,
  output logic signed [31:0] out_normal_u,
  output logic signed [31:0] out_normal_v,
  output logic               out_result_missing,
  output logic               out_status
);

  localparam logic signed [64:0] HALF65 = 65'sd536870912;
  localparam logic signed [67:0] HALF68 = 68'sd536870912;
  localparam logic signed [37:0] MAX32 = 38'sd2147483647;
  localparam logic signed [37:0] MIN32 = -38'sd2147483648;

  // B1: pick orientation
  logic vld1_r, vld2_r, vld3_r, vld4_r;
  logic signed [31:0] e1_w, e2_w, e1_1_r, e2_1_r, u1_r, v1_r;
  logic miss1_r;

  always_comb begin
    if (in_side.conf) begin
      e1_w = in_side.ox;
      e2_w = in_side.oy;
    end else if (in_rzero) begin
      e1_w = 32'sd0;
      e2_w = 32'sd0;
    end else begin
      e1_w = in_side.a_neg ? -$signed({1'b0, in_qa}) : $signed({1'b0, in_qa});
      e2_w = in_side.b_neg ? -$signed({1'b0, in_qb}) : $signed({1'b0, in_qb});
    end
  end

  always_ff @(posedge clk) begin
    e1_1_r <= e1_w;
    e2_1_r <= e2_w;
    u1_r <= in_side.u;
    v1_r <= in_side.v;
    miss1_r <= in_side.miss;
  end

  // B2: cross products
  logic signed [63:0] p1_r, p2_r;
  logic signed [31:0] e1_2_r, e2_2_r;
  logic miss2_r;

  always_ff @(posedge clk) begin
    p1_r <= u1_r * e2_1_r;
    p2_r <= v1_r * e1_1_r;
    e1_2_r <= e1_1_r;
    e2_2_r <= e2_1_r;
    miss2_r <= miss1_r;
  end

  // B3: n = round(u*e2 - v*e1)
  logic signed [64:0] dif;
  logic signed [34:0] n3_r;
  logic signed [31:0] e1_3_r, e2_3_r;
  logic miss3_r;

  always_comb begin
    dif = p1_r - p2_r + HALF65;
  end

  always_ff @(posedge clk) begin
    n3_r <= dif[64:30];
    e1_3_r <= e1_2_r;
    e2_3_r <= e2_2_r;
    miss3_r <= miss2_r;
  end

  // B4: project back
  logic signed [66:0] q1_r, q2_r;
  logic miss4_r;

  always_ff @(posedge clk) begin
    q1_r <= n3_r * e2_3_r;
    q2_r <= n3_r * e1_3_r;
    miss4_r <= miss3_r;
  end

  // B5: round, saturate, special cases
  logic signed [67:0] su, sv;
  logic signed [37:0] ru, rv;
  logic signed [31:0] nu_w, nv_w;
  logic strobe_r, miss_r, stat_r;
  logic signed [31:0] nu_r, nv_r;

  always_comb begin
    su = q1_r + HALF68;
    sv = HALF68 - q2_r;
    ru = su[67:30];
    rv = sv[67:30];
    if (ru > MAX32) nu_w = MAX32[31:0];
    else if (ru < MIN32) nu_w = MIN32[31:0];
    else nu_w = ru[31:0];
    if (rv > MAX32) nv_w = MAX32[31:0];
    else if (rv < MIN32) nv_w = MIN32[31:0];
    else nv_w = rv[31:0];
  end

  always_ff @(posedge clk) begin
    if (!orient_valid || miss4_r) begin
      nu_r <= 32'sd0;
      nv_r <= 32'sd0;
      miss_r <= 1'b1;
    end else begin
      nu_r <= nu_w;
      nv_r <= nv_w;
      miss_r <= 1'b0;
    end
    stat_r <= !orient_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      strobe_r <= vld4_r;
    end
  end

  assign out_strobe = strobe_r;
  assign out_normal_u = nu_r;
  assign out_normal_v = nv_r;
  assign out_result_missing = miss_r;
  assign out_status = stat_r;

endmodule

// File: design/vector_normal_component_core.sv
// Normal component of a grid vector against a loaded orientation. A beat on
// start carries one grid point (Q16.16 wind, missing flags, Q8.24 map
// scales); busy is always low, so a point may be issued every cycle. Each
// point yields exactly one result beat on out_strobe, in issue order; the
// receiver cannot stall, so results must be taken when shown. The pipeline
// has seven stages of scaling and normalizing, a 32-stage square root (one
// root bit per stage), a 32-stage rounding divider for both unit components,
// and five stages of projection and saturation. Orientation and tolerance
// registers are read live and must only be written while no point is in
// flight.
module vector_normal_component_core (
  input  logic               clk,
  input  logic               rst_n,
  // point channel
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_east_comp,
  input  logic signed [31:0] in_north_comp,
  input  logic               in_east_missing,
  input  logic               in_north_missing,
  input  logic [31:0]        in_scale_x,
  input  logic [31:0]        in_scale_y,
  // result channel
  output logic               out_strobe,
  output logic signed [31:0] out_normal_u,
  output logic signed [31:0] out_normal_v,
  output logic               out_result_missing,
  output logic               out_status,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Register file
  logic signed [31:0] orient_x_r, orient_y_r;
  logic orient_valid_r;
  logic [24:0] equal_tol_r;
  logic wr_en;
  vnc_pkg::vnc_reg_t reg_sel;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_sel = vnc_pkg::vnc_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_x_r <= 32'sd0;
      orient_y_r <= 32'sd0;
      orient_valid_r <= 1'b0;
      equal_tol_r <= vnc_pkg::TOL_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        vnc_pkg::REG_ORIENT_X: orient_x_r <= pwdata;
        vnc_pkg::REG_ORIENT_Y: orient_y_r <= pwdata;
        vnc_pkg::REG_ORIENT_VALID: orient_valid_r <= pwdata[0];
        vnc_pkg::REG_EQUAL_TOL: equal_tol_r <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      vnc_pkg::REG_ORIENT_X: prdata = orient_x_r;
      vnc_pkg::REG_ORIENT_Y: prdata = orient_y_r;
      vnc_pkg::REG_ORIENT_VALID: prdata = {31'd0, orient_valid_r};
      vnc_pkg::REG_EQUAL_TOL: prdata = {7'd0, equal_tol_r};
      default: prdata = 32'd0;
    endcase
  end

  vnc_pkg::vnc_cfg_t cfg;
  assign cfg = '{ox: orient_x_r, oy: orient_y_r, valid: orient_valid_r,
                 tol: equal_tol_r};

  // Fully pipelined: never busy
  assign busy = 1'b0;

  logic f_vld, s_vld, d_vld;
  vnc_pkg::vnc_side_t f_side, s_side, d_side;
  logic [62:0] f_rad;
  logic [31:0] s_root;
  logic [30:0] d_qa, d_qb;
  logic d_rzero;

  vnc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_u    (in_east_comp),
    .in_v    (in_north_comp),
    .in_miss (in_east_missing || in_north_missing),
    .in_sx   (in_scale_x),
    .in_sy   (in_scale_y),
    .cfg     (cfg),
    .out_vld (f_vld),
    .out_side(f_side),
    .out_rad (f_rad)
  );

  // length of the scaled orientation
  vnc_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (f_vld),
    .in_side (f_side),
    .in_rad  (f_rad),
    .out_vld (s_vld),
    .out_side(s_side),
    .out_root(s_root)
  );

  // unit components, rounded half up
  vnc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s_vld),
    .in_side  (s_side),
    .in_root  (s_root),
    .out_vld  (d_vld),
    .out_side (d_side),
    .out_qa   (d_qa),
    .out_qb   (d_qb),
    .out_rzero(d_rzero)
  );

  vnc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_vld            (d_vld),
    .in_side           (d_side),
    .in_qa             (d_qa),
    .in_qb             (d_qb),
    .in_rzero          (d_rzero),
    .orient_valid      (cfg.valid),
    .out_strobe        (out_strobe),
    .out_normal_u      (out_normal_u),
    .out_normal_v      (out_normal_v),
    .out_result_missing(out_result_missing),
    .out_status        (out_status)
  );

endmodule

// File: design/vnc_check.sv
module vnc_check (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input logic signed [31:0] out_normal_u,
  input logic signed [31:0] out_normal_v,
  input logic               out_result_missing,
  input logic               out_status
);

  // every accepted beat yields a result beat after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(vnc_pkg::PIPE_LAT) out_strobe)
    else $error("accepted point produced no result");

  // no result without an earlier accepted beat
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, vnc_pkg::PIPE_LAT))
    else $error("result without a matching point");

  a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result_missing) |->
      (out_normal_u == 32'sd0 && out_normal_v == 32'sd0))
    else $error("missing result with nonzero components");

  a_status_missing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status) |-> out_result_missing)
    else $error("no-orientation status without missing flag");

endmodule

bind vector_normal_component_core vnc_check u_vnc_check (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_normal_u      (out_normal_u),
  .out_normal_v      (out_normal_v),
  .out_result_missing(out_result_missing),
  .out_status        (out_status)
);
